[rtl/sep_pkg.sv]
package sep_pkg;

	localparam int MAX_ATOMS = 256;
	localparam int ADDR_W = $clog2(MAX_ATOMS);
	localparam int CNT_W = $clog2(MAX_ATOMS + 1);

	localparam logic [1:0] CFG_ATOM_COUNT = 2'd0;
	localparam logic [1:0] CFG_HEAVY_COUNT = 2'd1;

	localparam logic [49:0] CLOSE_D2 = 50'd42949672;
	localparam logic [25:0] KCAL_Q16 = 26'd41126435;
	localparam logic [47:0] SAT_A = 48'd14227079168;
	localparam logic [31:0] THIRD_MUL = 32'hAAAAAAAB;

	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic [15:0] pop;
		logic [15:0] zeta;
		logic [3:0] val;
	} atom_t;

	typedef struct packed {
		logic start;
		logic [16:0] v;
		logic [4:0] whole;
	} exp_req_t;

	function automatic logic [32:0] recip_n(input logic [3:0] n);
		logic [32:0] r;
		case (n)
			4'd1: r = 33'd4294967296;
			4'd2: r = 33'd2147483648;
			4'd3: r = 33'd1431655765;
			4'd4: r = 33'd1073741824;
			4'd5: r = 33'd858993459;
			4'd6: r = 33'd715827882;
			4'd7: r = 33'd613566756;
			4'd8: r = 33'd536870912;
			4'd9: r = 33'd477218588;
			4'd10: r = 33'd429496729;
			4'd11: r = 33'd390451572;
			4'd12: r = 33'd357913941;
			4'd13: r = 33'd330382099;
			4'd14: r = 33'd306783378;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/sep_atom_mem.sv]
module sep_atom_mem (
	input logic clk,
	input logic we,
	input logic [sep_pkg::ADDR_W-1:0] waddr,
	input sep_pkg::atom_t wdata,
	input logic re,
	input logic [sep_pkg::ADDR_W-1:0] raddr,
	output sep_pkg::atom_t rdata
);

	sep_pkg::atom_t mem [sep_pkg::MAX_ATOMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/sep_isqrt.sv]
module sep_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [49:0] d2,
	output logic busy,
	output logic [24:0] root
);

	logic [49:0] v_q;
	logic [49:0] res_q;
	logic [49:0] bm_q;
	logic busy_q;
	logic [49:0] trial;

	assign trial = res_q + bm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bm_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= d2;
			res_q <= '0;
			bm_q <= 50'd1 << 48;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bm_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bm_q <= bm_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[24:0];

endmodule

[rtl/sep_recip.sv]
module sep_recip (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [24:0] r,
	output logic busy,
	output logic [35:0] inv
);

	logic [24:0] r_q;
	logic [24:0] rem_q;
	logic [35:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [25:0] shifted;

	assign shifted = {rem_q, cnt_q == 6'd48};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == 6'd0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= r;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= 6'd48;
		end else if (busy_q) begin
			if (shifted >= {1'b0, r_q}) begin
				rem_q <= 25'(shifted - {1'b0, r_q});
				quo_q <= {quo_q[34:0], 1'b1};
			end else begin
				rem_q <= shifted[24:0];
				quo_q <= {quo_q[34:0], 1'b0};
			end
			cnt_q <= cnt_q - 6'd1;
		end
	end

	assign busy = busy_q;
	assign inv = quo_q;

endmodule

[rtl/sep_exp.sv]
module sep_exp (
	input logic clk,
	input logic arst_n,
	input sep_pkg::exp_req_t req,
	input logic [31:0] e1,
	output logic busy,
	output logic [32:0] e
);

	typedef enum logic [4:0] {
		EX_IDLE = 5'b00001,
		EX_MUL = 5'b00010,
		EX_RCP = 5'b00100,
		EX_ACC = 5'b01000,
		EX_POW = 5'b10000
	} ex_state_t;

	ex_state_t state_q;
	logic [16:0] v_q;
	logic [4:0] whole_q;
	logic [4:0] k_q;
	logic [3:0] n_q;
	logic [32:0] term_q;
	logic signed [34:0] sum_q;
	logic [49:0] prod_q;
	logic [32:0] a_q;
	logic [65:0] mr_q;
	logic [32:0] e_q;

	logic [32:0] q0;
	logic [36:0] qn;
	logic [32:0] rem;
	logic [32:0] nn;
	logic [1:0] adj;
	logic [32:0] q;
	logic signed [34:0] sum_nx;
	logic [64:0] pw;

	always_comb begin
		q0 = mr_q[64:32];
		qn = 37'(q0) * 37'(n_q);
		rem = a_q - qn[32:0];
		nn = 33'(n_q);
		adj = 2'(rem >= nn) + 2'(rem >= 33'(2 * nn)) + 2'(rem >= 33'(3 * nn));
		q = q0 + 33'(adj);
		sum_nx = n_q[0] ? sum_q - $signed({2'b00, q}) : sum_q + $signed({2'b00, q});
		pw = 65'(e_q) * 65'(e1) + (65'd1 << 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			case (state_q)
				EX_IDLE: begin
					if (req.start) begin
						state_q <= EX_MUL;
					end
				end
				EX_MUL: state_q <= EX_RCP;
				EX_RCP: state_q <= EX_ACC;
				EX_ACC: state_q <= (n_q == 4'd14) ? EX_POW : EX_MUL;
				EX_POW: begin
					if (k_q == whole_q) begin
						state_q <= EX_IDLE;
					end
				end
				default: state_q <= EX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EX_IDLE: begin
				v_q <= req.v;
				whole_q <= req.whole;
				term_q <= 33'd1 << 32;
				sum_q <= 35'sd1 <<< 32;
				n_q <= 4'd1;
				k_q <= '0;
			end
			EX_MUL: prod_q <= 50'(term_q) * 50'(v_q);
			EX_RCP: begin
				a_q <= prod_q[48:16];
				mr_q <= 66'(prod_q[48:16]) * 66'(sep_pkg::recip_n(n_q));
			end
			EX_ACC: begin
				term_q <= q;
				sum_q <= sum_nx;
				n_q <= n_q + 4'd1;
				if (n_q == 4'd14) begin
					e_q <= (sum_nx < 0) ? 33'd0 : sum_nx[32:0];
				end
			end
			EX_POW: begin
				if (k_q != whole_q) begin
					e_q <= pw[64:32];
					k_q <= k_q + 5'd1;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != EX_IDLE);
	assign e = e_q;

endmodule

[rtl/screened_electrostatic_potential_core.sv]
// Channel   | Ports                                  | Carries
// s (in)    | s_tvalid s_tready s_tdata s_tuser      | load or evaluate command
// m (out)   | m_tvalid m_tready m_tdata m_tuser      | potential and too-close flag
// cfg (in)  | cfg_valid cfg_ready cfg_addr cfg_data  | atom_count, heavy_count writes
// A load writes one atom table entry. An evaluation first forms exp(-1), then for each
// counted atom does the read, distance, check and square root, waits on the 49-step
// reciprocal divider running beside the exponential unit (which multiplies in exp(-1)
// once per whole unit of 2*zeta*r), and accumulates. Finishing states then scale, round
// and saturate the result. The atom table is a single-port-write, registered-read memory;
// it is not cleared at reset. The next command is taken while a result waits on m; an
// evaluation that finishes while the output register is still full holds until it is taken.
module screened_electrostatic_potential_core (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// atom_index, coord_x, coord_y, coord_z, population, zeta, valence, zero pad
	input logic [143:0] s_tdata,
	// cmd
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// potential
	output logic [31:0] m_tdata,
	// too_close
	output logic m_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_addr,
	input logic [8:0] cfg_data
);

	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_E1 = 20'h00002,
		ST_E1W = 20'h00004,
		ST_READ = 20'h00008,
		ST_DIST = 20'h00010,
		ST_CHECK = 20'h00020,
		ST_SQRT = 20'h00040,
		ST_PREP = 20'h00080,
		ST_EXPS = 20'h00100,
		ST_WAIT = 20'h00200,
		ST_Q2 = 20'h00400,
		ST_Q3 = 20'h00800,
		ST_POLY = 20'h01000,
		ST_PE = 20'h02000,
		ST_VS = 20'h04000,
		ST_ACCV = 20'h08000,
		ST_ACCP = 20'h10000,
		ST_FIN1 = 20'h20000,
		ST_FIN2 = 20'h40000,
		ST_OUT = 20'h80000
	} state_t;

	state_t state_q;
	logic [8:0] atom_count_q;
	logic [8:0] heavy_count_q;
	logic [23:0] px_q;
	logic [23:0] py_q;
	logic [23:0] pz_q;
	logic [sep_pkg::CNT_W-1:0] n_q;
	logic [sep_pkg::CNT_W-1:0] idx_q;
	logic [31:0] e1_q;
	logic [49:0] d2_q;
	logic [47:0] sq_q;
	logic [1:0] dist_cnt_q;
	logic [28:0] p_q;
	logic ezero_q;
	logic [32:0] e_q;
	logic [23:0] q2_q;
	logic [27:0] q3_q;
	logic [27:0] poly_q;
	logic [32:0] s_q;
	logic [36:0] vs_q;
	logic signed [63:0] acc_q;
	logic neg_q;
	logic sat_q;
	logic [59:0] fprod_q;
	logic [31:0] res_q;
	logic close_q;
	logic out_valid_q;
	logic [31:0] out_pot_q;
	logic out_close_q;

	sep_pkg::atom_t wr_atom;
	sep_pkg::atom_t atom;
	sep_pkg::exp_req_t exp_req;
	logic s_acc;
	logic mem_we;
	logic sq_busy;
	logic rcp_busy;
	logic exp_busy;
	logic [24:0] root;
	logic [35:0] inv;
	logic [32:0] exp_e;
	logic [29:0] x2p;
	logic signed [24:0] diff;
	logic signed [49:0] dsq;
	logic heavy;
	logic out_free;
	logic [63:0] mag;
	logic [47:0] amag;
	logic [60:0] rnd;
	logic [32:0] res_mag;
	logic [39:0] pp;
	logic [43:0] q2p;
	logic [59:0] third;
	logic [60:0] pe;
	logic [60:0] vsp;
	logic signed [53:0] popvs;
	logic [sep_pkg::CNT_W-1:0] n_lim;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;

	assign wr_atom = '{x: s_tdata[31:8], y: s_tdata[55:32], z: s_tdata[79:56],
		pop: s_tdata[95:80], zeta: s_tdata[111:96], val: s_tdata[115:112]};
	assign mem_we = s_acc && !s_tuser && (32'(s_tdata[7:0]) < sep_pkg::MAX_ATOMS);

	sep_atom_mem u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(sep_pkg::ADDR_W'(s_tdata[7:0])),
		.wdata(wr_atom),
		.re(state_q == ST_READ),
		.raddr(idx_q[sep_pkg::ADDR_W-1:0]),
		.rdata(atom)
	);

	sep_isqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_CHECK && d2_q > sep_pkg::CLOSE_D2),
		.d2(d2_q),
		.busy(sq_busy),
		.root(root)
	);

	sep_recip u_rcp (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_PREP),
		.r(root),
		.busy(rcp_busy),
		.inv(inv)
	);

	assign x2p = {p_q, 1'b0};

	always_comb begin
		exp_req = '{start: 1'b0, v: 17'd65536, whole: 5'd0};
		if (state_q == ST_E1) begin
			exp_req.start = 1'b1;
		end else if (state_q == ST_EXPS) begin
			exp_req.start = (x2p[29:21] == '0);
			exp_req.v = {1'b0, x2p[15:0]};
			exp_req.whole = x2p[20:16];
		end
	end

	sep_exp u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.req(exp_req),
		.e1(e1_q),
		.busy(exp_busy),
		.e(exp_e)
	);

	always_comb begin
		case (dist_cnt_q)
			2'd0: diff = $signed({atom.x[23], atom.x}) - $signed({px_q[23], px_q});
			2'd1: diff = $signed({atom.y[23], atom.y}) - $signed({py_q[23], py_q});
			default: diff = $signed({atom.z[23], atom.z}) - $signed({pz_q[23], pz_q});
		endcase
		dsq = diff * diff;
		heavy = 32'(idx_q) < 32'(heavy_count_q);
		pp = 40'(p_q[19:0]) * 40'(p_q[19:0]);
		q2p = 44'(q2_q) * 44'(p_q[19:0]);
		third = 60'(q3_q) * 60'(sep_pkg::THIRD_MUL);
		pe = 61'(poly_q) * 61'(e_q);
		vsp = 61'(inv) * 61'(s_q[32:8]);
		popvs = $signed(atom.pop) * $signed({1'b0, vs_q});
		mag = (acc_q < 0) ? 64'(-acc_q) : 64'(acc_q);
		amag = mag[63:16];
		rnd = 61'(fprod_q) + (61'd1 << 27);
		res_mag = rnd[60:28];
		if (sat_q) begin
			res_mag = neg_q ? (33'd1 << 31) : 33'h07FFFFFFF;
		end
		if (neg_q && res_mag > (33'd1 << 31)) begin
			res_mag = 33'd1 << 31;
		end else if (!neg_q && res_mag > 33'h07FFFFFFF) begin
			res_mag = 33'h07FFFFFFF;
		end
		n_lim = (32'(atom_count_q) < sep_pkg::MAX_ATOMS) ?
			sep_pkg::CNT_W'(atom_count_q) : sep_pkg::CNT_W'(sep_pkg::MAX_ATOMS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= '0;
			heavy_count_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_addr == sep_pkg::CFG_ATOM_COUNT) begin
				atom_count_q <= cfg_data;
			end else if (cfg_addr == sep_pkg::CFG_HEAVY_COUNT) begin
				heavy_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			n_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tuser) begin
						n_q <= n_lim;
						idx_q <= '0;
						state_q <= ST_E1;
					end
				end
				ST_E1: state_q <= ST_E1W;
				ST_E1W: begin
					if (!exp_busy) begin
						idx_q <= '0;
						state_q <= (n_q == '0) ? ST_FIN1 : ST_READ;
					end
				end
				ST_READ: state_q <= ST_DIST;
				ST_DIST: begin
					if (dist_cnt_q == 2'd3) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= (d2_q <= sep_pkg::CLOSE_D2) ? ST_OUT : ST_SQRT;
				ST_SQRT: begin
					if (!sq_busy) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_EXPS;
				ST_EXPS: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!exp_busy && !rcp_busy) begin
						if (ezero_q || exp_e == '0) begin
							state_q <= ST_VS;
						end else if (heavy) begin
							state_q <= ST_Q2;
						end else begin
							state_q <= ST_PE;
						end
					end
				end
				ST_Q2: state_q <= ST_Q3;
				ST_Q3: state_q <= ST_POLY;
				ST_POLY: state_q <= ST_PE;
				ST_PE: state_q <= ST_VS;
				ST_VS: state_q <= ST_ACCV;
				ST_ACCV: state_q <= ST_ACCP;
				ST_ACCP: begin
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == n_q) ? ST_FIN1 : ST_READ;
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= s_tdata[31:8];
				py_q <= s_tdata[55:32];
				pz_q <= s_tdata[79:56];
			end
			ST_E1W: begin
				e1_q <= exp_e[31:0];
				acc_q <= '0;
			end
			ST_READ: begin
				dist_cnt_q <= '0;
				d2_q <= '0;
			end
			ST_DIST: begin
				sq_q <= dsq[47:0];
				if (dist_cnt_q != 2'd0) begin
					d2_q <= d2_q + 50'(sq_q);
				end
				dist_cnt_q <= dist_cnt_q + 2'd1;
			end
			ST_CHECK: begin
				res_q <= '0;
				close_q <= 1'b1;
			end
			ST_PREP: p_q <= 29'((41'(atom.zeta) * 41'(root)) >> 12);
			ST_EXPS: ezero_q <= (x2p[29:21] != '0);
			ST_WAIT: begin
				e_q <= exp_e;
				s_q <= 33'd1 << 32;
				poly_q <= 28'd65536 + 28'(p_q);
			end
			ST_Q2: q2_q <= pp[39:16];
			ST_Q3: q3_q <= q2p[43:16];
			ST_POLY: poly_q <= 28'd65536 + 28'(p_q[19:0]) + 28'(p_q[19:1]) + 28'(q2_q)
				+ 28'(third[59:33]);
			ST_PE: s_q <= (pe[60:16] >= (45'd1 << 32)) ? 33'd0 :
				33'((45'd1 << 32) - pe[60:16]);
			ST_VS: vs_q <= vsp[60:24];
			ST_ACCV: acc_q <= acc_q + $signed(64'((52'(atom.val) * 52'(inv)) << 12));
			ST_ACCP: acc_q <= acc_q - 64'(popvs);
			ST_FIN1: begin
				neg_q <= acc_q < 0;
				sat_q <= amag >= sep_pkg::SAT_A;
				fprod_q <= 60'(amag[33:0]) * 60'(sep_pkg::KCAL_Q16);
			end
			ST_FIN2: begin
				res_q <= neg_q ? 32'(33'd0 - res_mag) : res_mag[31:0];
				close_q <= 1'b0;
			end
			ST_OUT: begin
				if (out_free) begin
					out_pot_q <= res_q;
					out_close_q <= close_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_pot_q;
	assign m_tuser = out_close_q;

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("too-close result carries a nonzero potential");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !exp_busy && !rcp_busy && !sq_busy)
		else $error("arithmetic unit busy while idle");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE && state_q != ST_OUT |-> idx_q <= n_q)
		else $error("atom index ran past the atom count");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result appeared without passing the output state");

endmodule
